// ===== rtl/core/rmq_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the rotation matrix block.
package rmq_pkg;

    localparam int MAX_ORDER_DEF = 12;
    localparam int FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH   = 4;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam int TAYLOR_TERMS = 8;
    localparam longint unsigned SIN_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};
    localparam longint unsigned COS_DIV [TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef enum logic [1:0] {
        ST_OK,
        ST_ZERO_QUAT,
        ST_ZERO_ORDER,
        ST_ZERO_AXIS
    } status_t;

    // quaternion handed from the front end to the matrix back end
    typedef struct packed {
        status_t            status;
        logic               neg;
        logic signed [15:0] qa;
        logic signed [15:0] qb;
        logic signed [15:0] qc;
        logic signed [15:0] qd;
    } rmq_quat_t;

    // sin(pi/k) in Q30, x = pi/k in Q30
    function automatic logic signed [31:0] sin_q30(input longint unsigned x, input int k);
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        if (k == 1) return 32'sd0;
        if (k == 2) return 32'(ONE_Q30);
        x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
        t  = x;
        s  = longint'(x);
        for (int i = 0; i < TAYLOR_TERMS; i++) begin
            t = ((t * x2) >> 30) / SIN_DIV[i];
            if (i[0] == 1'b0) s = s - longint'(t);
            else              s = s + longint'(t);
        end
        return 32'(s);
    endfunction

    // cos(pi/k) in Q30
    function automatic logic signed [31:0] cos_q30(input longint unsigned x, input int k);
        longint unsigned x2;
        longint unsigned t;
        longint          c;
        if (k == 1) return -32'(ONE_Q30);
        if (k == 2) return 32'sd0;
        x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
        t  = ONE_Q30;
        c  = longint'(ONE_Q30);
        for (int i = 0; i < TAYLOR_TERMS; i++) begin
            t = ((t * x2) >> 30) / COS_DIV[i];
            if (i[0] == 1'b0) c = c - longint'(t);
            else              c = c + longint'(t);
        end
        return 32'(c);
    endfunction

    // Q30 to Q14, round half away from zero
    function automatic logic signed [15:0] round_q16(input logic signed [31:0] v);
        logic [31:0] m;
        logic [15:0] q;
        m = v[31] ? 32'(-v) : 32'(v);
        q = 16'((m + 32'd32768) >> 16);
        return v[31] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== rtl/core/rmq_front.sv =====
// Front end: classifies items, builds the quaternion from axis and order (sqrt and divide pipes).
module rmq_front
    import rmq_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [15:0] quat_real,
    input  logic signed [15:0] quat_i,
    input  logic signed [15:0] quat_j,
    input  logic signed [15:0] quat_k,
    input  logic signed [4:0]  rot_order,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output logic               push,
    output rmq_quat_t          push_data,
    input  logic               full
);

    localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 15;
    localparam int FS        = 1 + (SQ_STEPS + 1) + 2 + (DIV_STEPS + 1);

    typedef struct packed {
        status_t            status;
        logic               neg;
        logic               op;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
        logic signed [31:0] f;
    } front_pl_t;

    // sin/cos of pi/k and the rounded scalar part, one entry per order
    logic signed [31:0] s_tab  [MAX_ORDER];
    logic signed [31:0] c_tab  [MAX_ORDER];
    logic signed [15:0] wp_tab [MAX_ORDER];
    logic signed [15:0] wn_tab [MAX_ORDER];

    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_tab
        localparam longint unsigned K  = g + 1;
        localparam longint unsigned XK = (PI_Q30 + K / 2) / K;
        localparam logic signed [31:0] SV = sin_q30(XK, g + 1);
        localparam logic signed [31:0] CV = cos_q30(XK, g + 1);
        localparam logic signed [15:0] WP = round_q16(CV);
        localparam logic signed [15:0] WN = -round_q16(SV);
        assign s_tab[g]  = SV;
        assign c_tab[g]  = CV;
        assign wp_tab[g] = WP;
        assign wn_tab[g] = WN;
    end

    logic [FS-1:0] valid_reg;
    logic          en;
    logic          accept;

    assign en       = !valid_reg[FS-1] || !full;
    assign in_ready = en;
    assign accept   = in_valid && en;
    assign push     = valid_reg[FS-1] && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[FS-2:0], accept};
        end
    end

    // ---- input stage: classify, table lookup, axis squares
    logic [4:0]         nmag;
    logic [IDX_W-1:0]   kidx;
    front_pl_t          pl1_next;
    logic signed [31:0] sx, sy, sz;

    assign sx = axis_x * axis_x;
    assign sy = axis_y * axis_y;
    assign sz = axis_z * axis_z;

    always_comb
    begin
        nmag = rot_order[4] ? 5'(-rot_order) : 5'(rot_order);
        if (nmag == 5'd0)
            kidx = '0;
        else if (int'(nmag) > MAX_ORDER)
            kidx = IDX_W'(MAX_ORDER - 1);
        else
            kidx = IDX_W'(nmag - 5'd1);

        pl1_next.op  = op;
        pl1_next.neg = op && rot_order[4];
        if (!op)
        begin
            pl1_next.status = (quat_real == 0 && quat_i == 0 && quat_j == 0 && quat_k == 0)
                              ? ST_ZERO_QUAT : ST_OK;
            pl1_next.v0 = quat_real;
            pl1_next.v1 = quat_i;
            pl1_next.v2 = quat_j;
            pl1_next.v3 = quat_k;
        end
        else
        begin
            if (rot_order == 5'sd0)
                pl1_next.status = ST_ZERO_ORDER;
            else if (axis_x == 0 && axis_y == 0 && axis_z == 0)
                pl1_next.status = ST_ZERO_AXIS;
            else
                pl1_next.status = ST_OK;
            pl1_next.v0 = rot_order[4] ? wn_tab[kidx] : wp_tab[kidx];
            pl1_next.v1 = axis_x;
            pl1_next.v2 = axis_y;
            pl1_next.v3 = axis_z;
        end
        pl1_next.f = rot_order[4] ? c_tab[kidx] : s_tab[kidx];
    end

    front_pl_t   pl1_reg;
    logic [30:0] sqx_reg, sqy_reg, sqz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl1_reg <= pl1_next;
            sqx_reg <= sx[30:0];
            sqy_reg <= sy[30:0];
            sqz_reg <= sz[30:0];
        end
    end

    // ---- square root pipe, one result bit per stage
    front_pl_t   isq_pl_reg [SQ_STEPS+1];
    logic [63:0] rem_reg    [SQ_STEPS+1];
    logic [63:0] root_reg   [SQ_STEPS+1];
    logic [31:0] sq_sum;

    assign sq_sum = 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            isq_pl_reg[0] <= pl1_reg;
            rem_reg[0]    <= {sq_sum, 32'd0};
            root_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        assign trial = root_reg[j] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                isq_pl_reg[j+1] <= isq_pl_reg[j];
                if (rem_reg[j] >= trial)
                begin
                    rem_reg[j+1]  <= rem_reg[j] - trial;
                    root_reg[j+1] <= (root_reg[j] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j] >> 1;
                end
            end
        end
    end

    // ---- scale axis by sin or cos
    front_pl_t          mul_pl_reg;
    logic signed [47:0] prod_reg [3];
    logic [31:0]        mlen_reg;
    logic signed [15:0] ax_sel [3];

    assign ax_sel[0] = isq_pl_reg[SQ_STEPS].v1;
    assign ax_sel[1] = isq_pl_reg[SQ_STEPS].v2;
    assign ax_sel[2] = isq_pl_reg[SQ_STEPS].v3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_pl_reg <= isq_pl_reg[SQ_STEPS];
            mlen_reg   <= root_reg[SQ_STEPS][31:0];
            for (int l = 0; l < 3; l++)
                prod_reg[l] <= isq_pl_reg[SQ_STEPS].f * ax_sel[l];
        end
    end

    // ---- sign and magnitude
    front_pl_t   abs_pl_reg;
    logic [45:0] mag_reg [3];
    logic        sgn_reg [3];
    logic [31:0] alen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_pl_reg <= mul_pl_reg;
            alen_reg   <= mlen_reg;
            for (int l = 0; l < 3; l++)
            begin
                sgn_reg[l] <= prod_reg[l][47];
                mag_reg[l] <= prod_reg[l][47] ? 46'(-prod_reg[l]) : 46'(prod_reg[l]);
            end
        end
    end

    // ---- rounded divide by the axis length, one quotient bit per stage
    front_pl_t   dv_pl_reg  [DIV_STEPS+1];
    logic [31:0] dlen_reg   [DIV_STEPS+1];
    logic [31:0] drem_reg   [DIV_STEPS+1][3];
    logic [14:0] dlo_reg    [DIV_STEPS+1][3];
    logic [14:0] dq_reg     [DIV_STEPS+1][3];
    logic        dsgn_reg   [DIV_STEPS+1][3];
    logic [46:0] dvd        [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            dvd[l] = 47'(mag_reg[l]) + 47'(alen_reg >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_pl_reg[0] <= abs_pl_reg;
            dlen_reg[0]  <= alen_reg;
            for (int l = 0; l < 3; l++)
            begin
                drem_reg[0][l] <= dvd[l][46:15];
                dlo_reg[0][l]  <= dvd[l][14:0];
                dq_reg[0][l]   <= '0;
                dsgn_reg[0][l] <= sgn_reg[l];
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [32:0] t [3];
        always_comb
        begin
            for (int l = 0; l < 3; l++)
                t[l] = {drem_reg[j][l], dlo_reg[j][l][DIV_STEPS-1-j]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_pl_reg[j+1] <= dv_pl_reg[j];
                dlen_reg[j+1]  <= dlen_reg[j];
                for (int l = 0; l < 3; l++)
                begin
                    dlo_reg[j+1][l]  <= dlo_reg[j][l];
                    dsgn_reg[j+1][l] <= dsgn_reg[j][l];
                    if (t[l] >= {1'b0, dlen_reg[j]})
                    begin
                        drem_reg[j+1][l] <= 32'(t[l] - {1'b0, dlen_reg[j]});
                        dq_reg[j+1][l]   <= {dq_reg[j][l][13:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[j+1][l] <= t[l][31:0];
                        dq_reg[j+1][l]   <= {dq_reg[j][l][13:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---- hand the quaternion to the queue
    logic signed [15:0] vec [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            vec[l] = dsgn_reg[DIV_STEPS][l] ? -$signed({1'b0, dq_reg[DIV_STEPS][l]})
                                            :  $signed({1'b0, dq_reg[DIV_STEPS][l]});
        push_data.status = dv_pl_reg[DIV_STEPS].status;
        push_data.neg    = dv_pl_reg[DIV_STEPS].neg;
        push_data.qa     = dv_pl_reg[DIV_STEPS].v0;
        if (dv_pl_reg[DIV_STEPS].op)
        begin
            push_data.qb = vec[0];
            push_data.qc = vec[1];
            push_data.qd = vec[2];
        end
        else
        begin
            push_data.qb = dv_pl_reg[DIV_STEPS].v1;
            push_data.qc = dv_pl_reg[DIV_STEPS].v2;
            push_data.qd = dv_pl_reg[DIV_STEPS].v3;
        end
    end

endmodule

// ===== rtl/core/rmq_queue.sv =====
// Small FIFO between the front end and the matrix back end.
module rmq_queue
    import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rmq_quat_t push_data,
    output logic      full,
    input  logic      pop,
    output rmq_quat_t pop_data,
    output logic      nonempty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    rmq_quat_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/rmq_back.sv =====
// Back end: quaternion products, squared norm, nine rounded divides, output register.
module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               nonempty,
    input  rmq_quat_t          pop_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] mat [9],
    output logic [1:0]         status
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int DW    = FRAC_BITS + 34;
    localparam int BS    = 3 + STEPS + 1;

    typedef struct packed {
        status_t status;
        logic    neg;
    } back_pl_t;

    logic [BS-1:0] valid_reg;
    logic          out_valid_reg;
    logic          en;
    logic          out_load;

    assign out_load  = !out_valid_reg || out_ready;
    assign en        = !valid_reg[BS-1] || out_load;
    assign pop       = en && nonempty;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                valid_reg <= {valid_reg[BS-2:0], nonempty};
            if (out_load)
                out_valid_reg <= valid_reg[BS-1];
        end
    end

    // ---- products
    back_pl_t           b1_pl_reg;
    logic signed [31:0] aa_reg, ab_reg, ac_reg, ad_reg, bb_reg;
    logic signed [31:0] bc_reg, bd_reg, cc_reg, cd_reg, dd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_pl_reg.status <= pop_data.status;
            b1_pl_reg.neg    <= pop_data.neg;
            aa_reg <= pop_data.qa * pop_data.qa;
            ab_reg <= pop_data.qa * pop_data.qb;
            ac_reg <= pop_data.qa * pop_data.qc;
            ad_reg <= pop_data.qa * pop_data.qd;
            bb_reg <= pop_data.qb * pop_data.qb;
            bc_reg <= pop_data.qb * pop_data.qc;
            bd_reg <= pop_data.qb * pop_data.qd;
            cc_reg <= pop_data.qc * pop_data.qc;
            cd_reg <= pop_data.qc * pop_data.qd;
            dd_reg <= pop_data.qd * pop_data.qd;
        end
    end

    // ---- numerators and norm
    back_pl_t           b2_pl_reg;
    logic [32:0]        norm2_reg;
    logic signed [33:0] num_reg [9];
    logic signed [33:0] num_next [9];

    always_comb
    begin
        num_next[0] = 34'(aa_reg) + 34'(bb_reg) - 34'(cc_reg) - 34'(dd_reg);
        num_next[1] = (34'(bc_reg) - 34'(ad_reg)) <<< 1;
        num_next[2] = (34'(ac_reg) + 34'(bd_reg)) <<< 1;
        num_next[3] = (34'(ad_reg) + 34'(bc_reg)) <<< 1;
        num_next[4] = 34'(aa_reg) - 34'(bb_reg) + 34'(cc_reg) - 34'(dd_reg);
        num_next[5] = (34'(cd_reg) - 34'(ab_reg)) <<< 1;
        num_next[6] = (34'(bd_reg) - 34'(ac_reg)) <<< 1;
        num_next[7] = (34'(ab_reg) + 34'(cd_reg)) <<< 1;
        num_next[8] = 34'(aa_reg) - 34'(bb_reg) - 34'(cc_reg) + 34'(dd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_pl_reg <= b1_pl_reg;
            norm2_reg <= 33'(aa_reg[30:0]) + 33'(bb_reg[30:0])
                       + 33'(cc_reg[30:0]) + 33'(dd_reg[30:0]);
            num_reg   <= num_next;
        end
    end

    // ---- magnitudes
    back_pl_t    b3_pl_reg;
    logic [32:0] norm3_reg;
    logic [32:0] mag_reg [9];
    logic        sgn_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_pl_reg <= b2_pl_reg;
            norm3_reg <= norm2_reg;
            for (int l = 0; l < 9; l++)
            begin
                sgn_reg[l] <= num_reg[l][33];
                mag_reg[l] <= num_reg[l][33] ? 33'(-num_reg[l]) : 33'(num_reg[l]);
            end
        end
    end

    // ---- rounded divide by the norm, one quotient bit per stage
    back_pl_t        bd_pl_reg   [STEPS+1];
    logic [32:0]     bd_norm_reg [STEPS+1];
    logic [32:0]     bd_rem_reg  [STEPS+1][9];
    logic [STEPS-1:0] bd_lo_reg  [STEPS+1][9];
    logic [STEPS-1:0] bd_q_reg   [STEPS+1][9];
    logic            bd_sgn_reg  [STEPS+1][9];
    logic [DW-1:0]   dvd [9];

    always_comb
    begin
        for (int l = 0; l < 9; l++)
            dvd[l] = (DW'(mag_reg[l]) << FRAC_BITS) + DW'(norm3_reg >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bd_pl_reg[0]   <= b3_pl_reg;
            bd_norm_reg[0] <= norm3_reg;
            for (int l = 0; l < 9; l++)
            begin
                bd_rem_reg[0][l] <= dvd[l][DW-1:STEPS];
                bd_lo_reg[0][l]  <= dvd[l][STEPS-1:0];
                bd_q_reg[0][l]   <= '0;
                bd_sgn_reg[0][l] <= sgn_reg[l];
            end
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_div
        logic [33:0] t [9];
        always_comb
        begin
            for (int l = 0; l < 9; l++)
                t[l] = {bd_rem_reg[j][l], bd_lo_reg[j][l][STEPS-1-j]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bd_pl_reg[j+1]   <= bd_pl_reg[j];
                bd_norm_reg[j+1] <= bd_norm_reg[j];
                for (int l = 0; l < 9; l++)
                begin
                    bd_lo_reg[j+1][l]  <= bd_lo_reg[j][l];
                    bd_sgn_reg[j+1][l] <= bd_sgn_reg[j][l];
                    if (t[l] >= {1'b0, bd_norm_reg[j]})
                    begin
                        bd_rem_reg[j+1][l] <= 33'(t[l] - {1'b0, bd_norm_reg[j]});
                        bd_q_reg[j+1][l]   <= {bd_q_reg[j][l][STEPS-2:0], 1'b1};
                    end
                    else
                    begin
                        bd_rem_reg[j+1][l] <= t[l][32:0];
                        bd_q_reg[j+1][l]   <= {bd_q_reg[j][l][STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---- sign, improper flip, error zeroing, output register
    logic [31:0]        qv   [9];
    logic [31:0]        sv   [9];
    logic signed [15:0] mat_next [9];
    logic signed [15:0] mat_reg  [9];
    status_t            status_reg;

    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            qv[l] = 32'(bd_q_reg[STEPS][l]);
            sv[l] = (bd_sgn_reg[STEPS][l] ^ bd_pl_reg[STEPS].neg) ? -qv[l] : qv[l];
            mat_next[l] = (bd_pl_reg[STEPS].status == ST_OK) ? $signed(sv[l][15:0]) : 16'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && valid_reg[BS-1])
        begin
            mat_reg    <= mat_next;
            status_reg <= bd_pl_reg[STEPS].status;
        end
    end

    assign mat    = mat_reg;
    assign status = status_reg;

endmodule

// ===== rtl/core/rotation_matrix_from_quaternion.sv =====
// Top level: quaternion or axis/order in, 3x3 rotation matrix in Q1.FRAC_BITS out.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | op, quat_real..quat_k, rot_order, axis_x..axis_z
//  out     | out_valid/out_ready | m00..m22, status
//
// One transfer per cycle in and out while the output is not stalled; the main
// pipes are the 32-stage axis square root, the 15-stage axis divide and the
// FRAC_BITS+1 stage norm divide. Reset clears only valid and pointer state.
// An output stall holds the back end; the front end keeps taking transfers
// until the four-entry queue is full and an item waits in its last stage.
module rotation_matrix_from_quaternion
    import rmq_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [15:0] quat_real,
    input  logic signed [15:0] quat_i,
    input  logic signed [15:0] quat_j,
    input  logic signed [15:0] quat_k,
    input  logic signed [4:0]  rot_order,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic [1:0]         status
);

    logic               push, full, pop, nonempty;
    rmq_quat_t          push_data, pop_data;
    logic signed [15:0] mat [9];

    rmq_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .quat_real (quat_real),
        .quat_i    (quat_i),
        .quat_j    (quat_j),
        .quat_k    (quat_k),
        .rot_order (rot_order),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rmq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .nonempty  (nonempty)
    );

    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mat       (mat),
        .status    (status)
    );

    assign m00 = mat[0];
    assign m01 = mat[1];
    assign m02 = mat[2];
    assign m10 = mat[3];
    assign m11 = mat[4];
    assign m12 = mat[5];
    assign m20 = mat[6];
    assign m21 = mat[7];
    assign m22 = mat[8];

endmodule

// ===== rtl/core/rmq_checker.sv =====
// Port-level checks on the rotation matrix block, bound to the top level.
module rmq_checker
    import rmq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] m00,
    input logic signed [15:0] m01,
    input logic signed [15:0] m02,
    input logic signed [15:0] m10,
    input logic signed [15:0] m11,
    input logic signed [15:0] m12,
    input logic signed [15:0] m20,
    input logic signed [15:0] m21,
    input logic signed [15:0] m22,
    input logic [1:0]         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(m00) && $stable(m11) && $stable(m22)
                                    && $stable(m01) && $stable(m12) && $stable(status))
        else $error("result changed while stalled");

    // any error code comes with an all-zero matrix
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> m00 == 0 && m01 == 0 && m02 == 0
            && m10 == 0 && m11 == 0 && m12 == 0 && m20 == 0 && m21 == 0 && m22 == 0)
        else $error("nonzero matrix with error status");

endmodule

bind rotation_matrix_from_quaternion rmq_checker u_rmq_checker (.*);

// ===== test/rotation_matrix_from_quaternion_tb.sv =====
// Testbench for the quaternion / axis-order to rotation matrix block.
`timescale 1ns / 1ps

module rotation_matrix_from_quaternion_tb;
    import rmq_pkg::*;

    localparam int  FRAC     = FRAC_BITS_DEF;
    localparam int  ORD_MAX  = MAX_ORDER_DEF;
    localparam int  WD_LIMIT = 5000;
    localparam int  LATENCY  = FRAC + 70;
    localparam int  OP_QUAT  = 0;
    localparam int  OP_AXIS  = 1;

    typedef struct {
        logic               op;
        logic signed [15:0] qr, qi, qj, qk;
        logic signed [4:0]  ord;
        logic signed [15:0] ax, ay, az;
    } item_t;

    typedef struct {
        logic signed [15:0] m [9];
        status_t            st;
    } matrix_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = 1'b0;
    logic signed [15:0] quat_real = '0, quat_i = '0, quat_j = '0, quat_k = '0;
    logic signed [4:0]  rot_order = '0;
    logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [1:0]         status;

    matrix_t expected_q [$];
    int      errors = 0;
    bit      idle_en = 1'b1;
    bit      long_hold = 1'b0;
    int      quiet_cycles = 0;

    rotation_matrix_from_quaternion i_dut (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mg, q;
        mg = num < 0 ? longint'(0) - num : num;
        q  = (mg + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, rem, b;
        r = 0; rem = x; b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void sin_cos(input longint unsigned k, output longint s, output longint c);
        longint unsigned x, x2, ts, tc, e;
        if (k == 1) begin s = 0; c = -longint'(ONE_Q30); return; end
        if (k == 2) begin s = longint'(ONE_Q30); c = 0; return; end
        x  = (PI_Q30 + k / 2) / k;
        x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
        ts = x;  s = longint'(x);
        tc = ONE_Q30; c = longint'(ONE_Q30);
        for (int i = 1; i <= 8; i++) begin
            e  = 2 * i;
            ts = ((ts * x2) >> 30) / (e * (e + 1));
            tc = ((tc * x2) >> 30) / ((e - 1) * e);
            if (i % 2 == 1) begin s = s - longint'(ts); c = c - longint'(tc); end
            else            begin s = s + longint'(ts); c = c + longint'(tc); end
        end
    endfunction

    function automatic longint clamp_term(input longint t, input longint unsigned norm);
        longint one, mg, v;
        one = longint'(1) << FRAC;
        mg  = t < 0 ? -t : t;
        v   = round_div(t < 0 ? -(mg << FRAC) : (mg << FRAC), norm);
        if (v > one)  v = one;
        if (v < -one) v = -one;
        return v;
    endfunction

    function automatic bit quat_to_matrix(input longint a, b, c, d, output longint m [9]);
        longint aa, ab, ac, ad, bb, bc, bd, cc, cd, dd;
        longint unsigned norm;
        aa = a*a; ab = a*b; ac = a*c; ad = a*d;
        bb = b*b; bc = b*c; bd = b*d; cc = c*c; cd = c*d; dd = d*d;
        norm = aa + bb + cc + dd;
        foreach (m[i]) m[i] = 0;
        if (norm == 0) return 1'b0;
        m[0] = clamp_term(aa + bb - cc - dd, norm);
        m[1] = clamp_term(2 * (bc - ad), norm);
        m[2] = clamp_term(2 * (ac + bd), norm);
        m[3] = clamp_term(2 * (ad + bc), norm);
        m[4] = clamp_term(aa - bb + cc - dd, norm);
        m[5] = clamp_term(2 * (cd - ab), norm);
        m[6] = clamp_term(2 * (bd - ac), norm);
        m[7] = clamp_term(2 * (ab + cd), norm);
        m[8] = clamp_term(aa - bb - cc + dd, norm);
        return 1'b1;
    endfunction

    function automatic matrix_t predict_matrix(input item_t it);
        matrix_t r;
        longint m [9];
        longint n, ax, ay, az, s30, c30, w, f;
        longint unsigned sq, k, len16;
        foreach (m[i]) m[i] = 0;
        r.st = ST_OK;
        if (it.op == OP_QUAT) begin
            if (!quat_to_matrix(it.qr, it.qi, it.qj, it.qk, m)) r.st = ST_ZERO_QUAT;
        end else begin
            n = it.ord; ax = it.ax; ay = it.ay; az = it.az;
            if (n == 0) begin
                r.st = ST_ZERO_ORDER;
            end else begin
                sq = ax*ax + ay*ay + az*az;
                if (sq == 0) begin
                    r.st = ST_ZERO_AXIS;
                end else begin
                    k = n < 0 ? -n : n;
                    if (k > ORD_MAX) k = ORD_MAX;
                    len16 = int_sqrt(sq << 32);
                    sin_cos(k, s30, c30);
                    if (n > 0) begin w = round_div(c30, 65536); f = s30; end
                    else       begin w = -round_div(s30, 65536); f = c30; end
                    void'(quat_to_matrix(w, round_div(f * ax, len16),
                        round_div(f * ay, len16), round_div(f * az, len16), m));
                    if (n < 0) foreach (m[i]) m[i] = -m[i];
                end
            end
        end
        foreach (m[i]) r.m[i] = m[i][15:0];
        return r;
    endfunction

    // ---------------- driving ----------------
    task automatic send_item(input item_t it);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= it.op;
        quat_real <= it.qr; quat_i <= it.qi; quat_j <= it.qj; quat_k <= it.qk;
        rot_order <= it.ord;
        axis_x    <= it.ax; axis_y <= it.ay; axis_z <= it.az;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(predict_matrix(it));
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic item_t quat_item(input int qr, qi, qj, qk);
        item_t it;
        it = '{default: '0};
        it.op = 1'(OP_QUAT); it.qr = 16'(qr); it.qi = 16'(qi); it.qj = 16'(qj);
        it.qk = 16'(qk);
        it.ord = 5'($urandom); it.ax = 16'($urandom); it.ay = 16'($urandom);
        it.az = 16'($urandom);
        return it;
    endfunction

    function automatic item_t axis_item(input int n, ax, ay, az);
        item_t it;
        it = quat_item($urandom, $urandom, $urandom, $urandom);
        it.op = 1'(OP_AXIS); it.ord = 5'(n); it.ax = 16'(ax); it.ay = 16'(ay);
        it.az = 16'(az);
        return it;
    endfunction

    function automatic item_t random_item();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return quat_item($urandom, $urandom, $urandom, $urandom);
            1, 2, 3: return quat_item($signed(16'($urandom_range(0, 32767))) - 16384,
                            $urandom_range(0, 32767) - 16384,
                            $urandom_range(0, 32767) - 16384,
                            $urandom_range(0, 32767) - 16384);
            4: return quat_item($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
                                $urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2);
            5, 6: return axis_item(int'($urandom_range(0, 24)) - 12, $urandom, $urandom,
                                   $urandom);
            7, 8: return axis_item(int'($urandom_range(0, 24)) - 12,
                                   int'($urandom_range(0, 20)) - 10,
                                   int'($urandom_range(0, 20)) - 10,
                                   int'($urandom_range(0, 20)) - 10);
            default: return axis_item(int'($urandom_range(0, 31)) - 16, 0, 0,
                                      $urandom_range(0, 1));
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_item(quat_item(0, 0, 0, 0));
        send_item(quat_item(16384, 0, 0, 0));
        send_item(quat_item(0, 16384, 0, 0));
        send_item(quat_item(0, 0, 16384, 0));
        send_item(quat_item(0, 0, 0, 16384));
        send_item(quat_item(32767, 32767, 32767, 32767));
        send_item(quat_item(-32768, -32768, -32768, -32768));
        send_item(quat_item(-32768, 32767, -1, 1));
        send_item(quat_item(1, 0, 0, 0));
        send_item(axis_item(0, 1, 2, 3));
        send_item(axis_item(5, 0, 0, 0));
        send_item(axis_item(-5, 0, 0, 0));
        send_item(axis_item(1, 1, 0, 0));
        send_item(axis_item(2, 0, 1, 0));
        send_item(axis_item(3, 0, 0, 7));
        send_item(axis_item(12, 32767, 32767, 32767));
        send_item(axis_item(-12, -32768, -32768, -32768));
        send_item(axis_item(-1, 0, 0, -1));
        send_item(axis_item(-2, 3, -4, 0));
        send_item(axis_item(-16, 100, 0, 0));
        send_item(axis_item(15, 0, -32768, 32767));
        stop_sending();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_item(random_item());
        stop_sending();
    endtask

    // more items than the pipeline and queue hold, sent without gaps
    task automatic test_backpressure();
        idle_en   = 1'b0;
        long_hold = 1'b1;
        repeat (100) send_item(random_item());
        stop_sending();
        wait (long_hold == 1'b0);
        idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_item(random_item());
        stop_sending();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (30) send_item(random_item());
        stop_sending();
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        repeat (120) send_item(random_item());
        stop_sending();
    endtask

    // ---------------- receiver ----------------
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 8);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        matrix_t e;
        logic signed [15:0] got [9];
        string names [9];
        names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = expected_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== e.m[i]) begin
                        $error("%s expected %0d actual %0d", names[i], e.m[i], got[i]);
                        errors++;
                    end
                if (status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        test_backpressure();
        test_random(150);
        test_drain_pause();
        test_full_rate();
        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_queue.sv
rtl/core/rmq_back.sv
rtl/core/rotation_matrix_from_quaternion.sv
rtl/core/rmq_checker.sv
test/rotation_matrix_from_quaternion_tb.sv
